// File: hw/rtl/ectc_pkg.sv
// ectc_pkg: shared types, constants and calendar helpers for the epoch converter
// used by ectc_front, ectc_queue, ectc_back and epoch_seconds_to_calendar_top
// no dependencies
package ectc_pkg;

    // reciprocal multipliers for exact constant division (ceil(2^k / d))
    localparam logic [31:0] DIV60_SEC_MUL  = 32'd2290649225; // k = 37, x < 2^31
    localparam logic [26:0] DIV60_MIN_MUL  = 27'd71582789;   // k = 32, x < 2^26
    localparam logic [20:0] DIV24_HOUR_MUL = 21'd1398102;    // k = 25, x < 2^20
    localparam logic [15:0] DIV7_MUL       = 16'd37450;      // k = 18, x < 2^15
    localparam logic [15:0] DIV365_MUL     = 16'd45965;      // k = 24, x < 2^15

    localparam int EPOCH_DAY_BIAS = 25508;
    localparam logic [7:0] YEAR_GUESS_BASE = 8'd69;
    localparam logic [14:0] EPOCH_WDAY = 15'd4;   // epoch day was a thursday

    // first-day-minus-two offsets per month, january first, march-based
    localparam int MONTH_BASE [12] = '{305, 336, -1, 30, 60, 91, 121, 152, 183, 213, 244, 274};

    // month order for the offset search, march first
    localparam logic [3:0] MARCH_ORDER [12] = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                                                 4'd8, 4'd9, 4'd10, 4'd11, 4'd0, 4'd1};

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [8:0] OFF_MAX   = 9'd366;

    // time-of-day split, weekday and day count of one item
    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [2:0]  wday;
        logic [14:0] days;
    } ectc_item_t;

    // day number of the last day of february of year y, relative to the epoch
    function automatic logic signed [17:0] feb_end(input logic [7:0] y);
        int yi;
        int cent;
        int sum;
        yi   = int'(y);
        cent = (y >= 8'd200) ? 2 : ((y >= 8'd100) ? 1 : 0);
        sum  = yi * 365 + (yi >>> 2) - cent + ((cent + 3) >>> 2) - EPOCH_DAY_BIAS - 1;
        return 18'(sum);
    endfunction

    // month from the offset within the march-based year
    function automatic logic [3:0] month_of(input logic [8:0] off);
        logic [3:0] m;
        m = MARCH_ORDER[0];
        for (int i = 0; i < 12; i++)
        begin
            if (int'(off) >= MONTH_BASE[MARCH_ORDER[i]] + 2)
            begin
                m = MARCH_ORDER[i];
            end
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/ectc_front.sv
// ectc_front: takes an epoch-seconds item and splits it into time of day,
// day count and weekday with reciprocal multiplies; depends on ectc_pkg
module ectc_front import ectc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] epoch_seconds,
    output logic        push,
    output ectc_item_t  push_item,
    input  logic        queue_full
);

    typedef enum logic [5:0] {
        F_IDLE   = 6'b000001,
        F_MIN    = 6'b000010,
        F_HOUR   = 6'b000100,
        F_DAY    = 6'b001000,
        F_WDAY   = 6'b010000,
        F_PUSH   = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [30:0] secs_reg,  secs_next;
    logic [62:0] p1_reg,    p1_next;
    logic [52:0] p2_reg,    p2_next;
    logic [40:0] p3_reg,    p3_next;
    logic [30:0] p4_reg,    p4_next;
    logic [25:0] mins_reg,  mins_next;
    logic [19:0] hours_reg, hours_next;
    ectc_item_t  item_reg,  item_next;

    logic [25:0] mins;
    logic [19:0] hours;
    logic [14:0] days;
    logic [12:0] q7;
    logic [31:0] mins_x60;
    logic [25:0] hours_x60;
    logic [19:0] days_x24;
    logic [14:0] wday_x;

    assign mins      = p1_reg[62:37];
    assign hours     = p2_reg[51:32];
    assign days      = p3_reg[39:25];
    assign q7        = p4_reg[30:18];
    assign mins_x60  = 32'(mins) * 32'd60;
    assign hours_x60 = 26'(hours) * 26'd60;
    assign days_x24  = 20'(days) * 20'd24;
    assign wday_x    = item_reg.days + EPOCH_WDAY;

    assign busy      = (state_reg != F_IDLE);
    assign push      = (state_reg == F_PUSH) && !queue_full;
    assign push_item = item_reg;

    always_comb
    begin
        state_next = state_reg;
        secs_next  = secs_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        p3_next    = p3_reg;
        p4_next    = p4_reg;
        mins_next  = mins_reg;
        hours_next = hours_reg;
        item_next  = item_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    secs_next  = epoch_seconds;
                    p1_next    = 63'(epoch_seconds) * 63'(DIV60_SEC_MUL);
                    state_next = F_MIN;
                end
            end
            F_MIN:
            begin
                item_next.sec = 6'({1'b0, secs_reg} - mins_x60);
                mins_next     = mins;
                p2_next       = 53'(mins) * 53'(DIV60_MIN_MUL);
                state_next    = F_HOUR;
            end
            F_HOUR:
            begin
                item_next.min = 6'(mins_reg - hours_x60);
                hours_next    = hours;
                p3_next       = 41'(hours) * 41'(DIV24_HOUR_MUL);
                state_next    = F_DAY;
            end
            F_DAY:
            begin
                item_next.hour = 5'(hours_reg - days_x24);
                item_next.days = days;
                p4_next        = 31'(days + EPOCH_WDAY) * 31'(DIV7_MUL);
                state_next     = F_WDAY;
            end
            F_WDAY:
            begin
                item_next.wday = 3'(wday_x - 15'(q7) * 15'd7);
                state_next     = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg  <= secs_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        p3_reg    <= p3_next;
        p4_reg    <= p4_next;
        mins_reg  <= mins_next;
        hours_reg <= hours_next;
        item_reg  <= item_next;
    end

endmodule

// File: hw/rtl/ectc_queue.sv
// ectc_queue: small fifo of split items between the front and back parts
// depends on ectc_pkg for the item type
module ectc_queue import ectc_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ectc_item_t push_item,
    input  logic       pop,
    output ectc_item_t pop_item,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ectc_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/ectc_back.sv
// ectc_back: march-based year search, month and day-of-month lookup and the
// result registers; depends on ectc_pkg
module ectc_back import ectc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  ectc_item_t  queue_item,
    output logic        pop,
    output logic        done,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month,
    output logic [7:0]  year_since_1900,
    output logic [2:0]  weekday,
    output logic [14:0] days_since_epoch
);

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_GUESS  = 5'b00010,
        B_SEARCH = 5'b00100,
        B_MONTH  = 5'b01000,
        B_FINISH = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    ectc_item_t         item_reg,  item_next;
    logic [30:0]        p365_reg,  p365_next;
    logic [7:0]         year_reg,  year_next;
    logic signed [17:0] lo_reg,    lo_next;
    logic signed [17:0] hi_reg,    hi_next;
    logic [8:0]         off_reg,   off_next;
    logic [3:0]         month_reg, month_next;

    logic               done_reg,  done_next;
    logic [5:0]         sec_out_reg,   sec_out_next;
    logic [5:0]         min_out_reg,   min_out_next;
    logic [4:0]         hour_out_reg,  hour_out_next;
    logic [4:0]         mday_out_reg,  mday_out_next;
    logic [3:0]         month_out_reg, month_out_next;
    logic [7:0]         year_out_reg,  year_out_next;
    logic [2:0]         wday_out_reg,  wday_out_next;
    logic [14:0]        days_out_reg,  days_out_next;

    logic [7:0]         year_guess;
    logic signed [17:0] days_s;
    logic signed [17:0] diff;
    int                 mday_full;

    assign year_guess = 8'(p365_reg[30:24]) + YEAR_GUESS_BASE;
    assign days_s     = $signed({3'b000, item_reg.days});
    assign diff       = days_s - lo_reg;
    assign mday_full  = int'(off_reg) - MONTH_BASE[month_reg] - 1;

    assign pop = (state_reg == B_IDLE) && !queue_empty;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        p365_next      = p365_reg;
        year_next      = year_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        off_next       = off_reg;
        month_next     = month_reg;
        done_next      = 1'b0;
        sec_out_next   = sec_out_reg;
        min_out_next   = min_out_reg;
        hour_out_next  = hour_out_reg;
        mday_out_next  = mday_out_reg;
        month_out_next = month_out_reg;
        year_out_next  = year_out_reg;
        wday_out_next  = wday_out_reg;
        days_out_next  = days_out_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    item_next  = queue_item;
                    p365_next  = 31'(queue_item.days) * 31'(DIV365_MUL);
                    state_next = B_GUESS;
                end
            end
            B_GUESS:
            begin
                year_next  = year_guess;
                hi_next    = feb_end(year_guess);
                lo_next    = feb_end(year_guess);
                state_next = B_SEARCH;
            end
            B_SEARCH:
            begin
                if (hi_reg < days_s)
                begin
                    lo_next   = hi_reg;
                    year_next = year_reg + 8'd1;
                    hi_next   = feb_end(year_reg + 8'd1);
                end
                else
                begin
                    if (diff < 0)
                    begin
                        off_next = '0;
                    end
                    else if (diff > $signed({9'd0, OFF_MAX}))
                    begin
                        off_next = OFF_MAX;
                    end
                    else
                    begin
                        off_next = diff[8:0];
                    end
                    state_next = B_MONTH;
                end
            end
            B_MONTH:
            begin
                month_next = month_of(off_reg);
                state_next = B_FINISH;
            end
            B_FINISH:
            begin
                done_next      = 1'b1;
                sec_out_next   = item_reg.sec;
                min_out_next   = item_reg.min;
                hour_out_next  = item_reg.hour;
                wday_out_next  = item_reg.wday;
                days_out_next  = item_reg.days;
                mday_out_next  = 5'(mday_full);
                month_out_next = month_reg;
                // march through december belong to the year before the search result
                year_out_next  = (month_reg > MONTH_FEB) ? year_reg - 8'd1 : year_reg;
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        p365_reg      <= p365_next;
        year_reg      <= year_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        off_reg       <= off_next;
        month_reg     <= month_next;
        sec_out_reg   <= sec_out_next;
        min_out_reg   <= min_out_next;
        hour_out_reg  <= hour_out_next;
        mday_out_reg  <= mday_out_next;
        month_out_reg <= month_out_next;
        year_out_reg  <= year_out_next;
        wday_out_reg  <= wday_out_next;
        days_out_reg  <= days_out_next;
    end

    assign done             = done_reg;
    assign second           = sec_out_reg;
    assign minute           = min_out_reg;
    assign hour             = hour_out_reg;
    assign day_of_month     = mday_out_reg;
    assign month            = month_out_reg;
    assign year_since_1900  = year_out_reg;
    assign weekday          = wday_out_reg;
    assign days_since_epoch = days_out_reg;

    // a result strobe never stays high on back-to-back clock edges
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // the strobe only follows a completed month lookup
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == B_FINISH))
        else $error("result strobe without finish step");

    // a delivered date has a month in range, a nonzero day of month and a year from 70 to 138
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (month_out_reg <= 4'd11 && mday_out_reg != 5'd0
                      && year_out_reg >= 8'd70 && year_out_reg <= 8'd138))
        else $error("result date out of range");

endmodule

// File: hw/rtl/epoch_seconds_to_calendar_top.sv
// epoch_seconds_to_calendar_top: epoch seconds to utc calendar date converter
// instantiates ectc_front, ectc_queue and ectc_back; depends on ectc_pkg
//
// usage
//   input channel: drive epoch_seconds and raise start; the item is taken at
//   the clock edge where start is high and busy is low. busy stays high while
//   the front part splits the item (reciprocal multiplies for /60, /60, /24
//   and the weekday mod 7) and waits for a free queue slot
//   result channel: done is high for exactly one cycle with all result fields
//   valid in that cycle; the receiver cannot stall, so results are never held
//   steps: the front part runs its minute, hour, day and weekday steps up to
//   the queue write, then the back part runs pop, year guess, one or two
//   search steps and the closing compare, month lookup and finish; the year
//   search steps one year per cycle from the days/365 guess
//   throughput: the front sequencer takes no new item until it has pushed
//   the last one; the sustained rate is set by the back part, with the queue
//   absorbing the difference (busy stays high when it is full)
//   reset: rst_n clears both sequencers and the queue; no item is in flight
//   and done is low after reset
module epoch_seconds_to_calendar_top import ectc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] epoch_seconds,
    output logic        done,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month,
    output logic [7:0]  year_since_1900,
    output logic [2:0]  weekday,
    output logic [14:0] days_since_epoch
);

    // split item from the front part toward the queue
    logic       push;
    ectc_item_t push_item;
    // queue head toward the back part
    logic       pop;
    ectc_item_t pop_item;
    logic       queue_full;
    logic       queue_empty;

    // front: accept, time of day, day count and weekday
    ectc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .epoch_seconds (epoch_seconds),
        .push          (push),
        .push_item     (push_item),
        .queue_full    (queue_full)
    );

    // decoupling queue so the back part's search time stalls the front only when the queue is full
    ectc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // back: year search, month and day of month, result strobe
    ectc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .queue_empty      (queue_empty),
        .queue_item       (pop_item),
        .pop              (pop),
        .done             (done),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .day_of_month     (day_of_month),
        .month            (month),
        .year_since_1900  (year_since_1900),
        .weekday          (weekday),
        .days_since_epoch (days_since_epoch)
    );

endmodule
